@@ rtl/sorted_list_insert_delete_unit_assert.svh @@
// assertion macros for the sorted list unit
`ifndef SORTED_LIST_INSERT_DELETE_UNIT_ASSERT_SVH
`define SORTED_LIST_INSERT_DELETE_UNIT_ASSERT_SVH

// expression holds at every clock edge out of reset
`define SLIDU_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);

// antecedent at an edge implies consequent at the same edge
`define SLIDU_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// antecedent at an edge implies consequent at the next edge
`define SLIDU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/slidu_pkg.sv @@
// types and codes shared by the sorted list unit
package slidu_pkg;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned COUNT_W = 6;

  typedef enum logic [1:0] {
    CMD_INSERT    = 2'd0,
    CMD_DELETE    = 2'd1,
    CMD_READ_ASC  = 2'd2,
    CMD_READ_DESC = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_DONE    = 3'd0,
    ST_FULL    = 3'd1,
    ST_MISSING = 3'd2,
    ST_ENTRY   = 3'd3,
    ST_EMPTY   = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_INSERT,
    OP_DELETE,
    OP_ROT_LEFT,
    OP_ROT_RIGHT
  } op_e;

  typedef enum logic {
    FSM_IDLE,
    FSM_READ
  } fsm_e;

  typedef struct packed {
    op_e                        op;
    logic signed [VALUE_W-1:0]  value;
  } slidu_ctl_t;

endpackage

@@ rtl/slidu_cell.sv @@
// one cell of the sorted chain: holds one entry and trades it with its neighbors
module slidu_cell import slidu_pkg::*; #(
  parameter int unsigned Idx  = 0,
  parameter int unsigned CntW = 6
) (
  input  logic                      clk_i,
  input  slidu_ctl_t                ctl_i,
  input  logic [CntW-1:0]           count_i,
  input  logic signed [VALUE_W-1:0] left_val_i,
  input  logic                      left_open_i,
  input  logic signed [VALUE_W-1:0] right_val_i,
  input  logic                      hit_i,
  output logic signed [VALUE_W-1:0] val_o,
  output logic                      open_o,
  output logic                      hit_o
);

  logic signed [VALUE_W-1:0] val_q, val_d;
  logic                      used;

  assign used   = CntW'(Idx) < count_i;
  // open: the new value belongs here or earlier
  assign open_o = !used || (val_q > ctl_i.value);
  // prefix of matches, first match and everything after it shifts left
  assign hit_o  = hit_i || (used && (val_q == ctl_i.value));
  assign val_o  = val_q;

  always_comb begin
    val_d = val_q;
    case (ctl_i.op)
      OP_INSERT: begin
        if (left_open_i) begin
          val_d = left_val_i;
        end else if (open_o) begin
          val_d = ctl_i.value;
        end
      end
      OP_DELETE: begin
        if (hit_o) begin
          val_d = right_val_i;
        end
      end
      OP_ROT_LEFT:  val_d = right_val_i;
      OP_ROT_RIGHT: val_d = left_val_i;
      default:      val_d = val_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

endmodule

@@ rtl/sorted_list_insert_delete_unit.sv @@
// sorted list unit: chain of compare-and-shift cells with a registered result port
//
//   channel   dir  tdata                              tuser        tlast
//   s_axis    in   value[31:0]                        cmd[1:0]     -
//   m_axis    out  entry_value[31:0] entry_count[37:32] status[2:0] last
//
// insert, delete and a read of an empty list complete in the accept cycle.
// a non-empty read is accepted, then the cell ring rotates once all the way round, one
// step per cycle while the result register is free, and entries leave from one end.
// reset clears the entry count and the control state; cell contents are not reset.
// a stalled result holds the chain; the next command is taken once the result
// register is free or being drained.
module sorted_list_insert_delete_unit import slidu_pkg::*; #(
  parameter int unsigned CAPACITY = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // value[31:0]
  input  logic [1:0]  s_axis_tuser,   // cmd[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // entry_value[31:0], entry_count[37:32], zero[39:38]
  output logic [2:0]  m_axis_tuser,   // status[2:0]
  output logic        m_axis_tlast
);

  localparam int unsigned CntW  = $clog2(CAPACITY + 1);
  localparam int unsigned StepW = $clog2(CAPACITY);

  fsm_e                      state_q, state_d;
  logic [CntW-1:0]           count_q, count_d;
  logic [StepW-1:0]          step_q, step_d;
  logic                      desc_q, desc_d;

  logic                      out_valid_q, out_valid_d;
  status_e                   out_status_q, out_status_d;
  logic signed [VALUE_W-1:0] out_value_q, out_value_d;
  logic [COUNT_W-1:0]        out_count_q, out_count_d;
  logic                      out_last_q, out_last_d;
  logic                      out_load;

  slidu_ctl_t                ctl;
  logic signed [VALUE_W-1:0] cell_val  [CAPACITY];
  logic                      cell_open [CAPACITY];
  logic                      cell_hit  [CAPACITY];

  logic                      slot_free;
  logic                      accept;
  logic                      found;
  logic                      full;
  logic [CntW:0]             step_sum;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    localparam int unsigned L = (i + CAPACITY - 1) % CAPACITY;
    localparam int unsigned R = (i + 1) % CAPACITY;
    slidu_cell #(
      .Idx  (i),
      .CntW (CntW)
    ) u_cell (
      .clk_i       (clk_i),
      .ctl_i       (ctl),
      .count_i     (count_q),
      .left_val_i  (cell_val[L]),
      .left_open_i ((i == 0) ? 1'b0 : cell_open[L]),
      .right_val_i (cell_val[R]),
      .hit_i       ((i == 0) ? 1'b0 : cell_hit[L]),
      .val_o       (cell_val[i]),
      .open_o      (cell_open[i]),
      .hit_o       (cell_hit[i])
    );
  end

  assign slot_free     = !out_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == FSM_IDLE) && slot_free;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign found         = cell_hit[CAPACITY-1];
  assign full          = count_q == CntW'(CAPACITY);
  assign step_sum      = (CntW+1)'(step_q) + (CntW+1)'(count_q);

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    step_d       = step_q;
    desc_d       = desc_q;
    ctl.op       = OP_HOLD;
    ctl.value    = s_axis_tdata;
    out_load     = 1'b0;
    out_status_d = ST_DONE;
    out_value_d  = '0;
    out_last_d   = 1'b1;

    case (state_q)
      FSM_IDLE: begin
        if (accept) begin
          out_load = 1'b1;
          case (cmd_e'(s_axis_tuser))
            CMD_INSERT: begin
              if (full) begin
                out_status_d = ST_FULL;
              end else begin
                ctl.op  = OP_INSERT;
                count_d = count_q + 1'b1;
              end
            end
            CMD_DELETE: begin
              if (found) begin
                ctl.op  = OP_DELETE;
                count_d = count_q - 1'b1;
              end else begin
                out_status_d = ST_MISSING;
              end
            end
            default: begin
              if (count_q == '0) begin
                out_status_d = ST_EMPTY;
              end else begin
                out_load = 1'b0;
                state_d  = FSM_READ;
                step_d   = '0;
                desc_d   = s_axis_tuser == CMD_READ_DESC;
              end
            end
          endcase
        end
      end
      FSM_READ: begin
        if (slot_free) begin
          step_d       = step_q + 1'b1;
          out_status_d = ST_ENTRY;
          if (desc_q) begin
            // rotate right; entries show at the top cell once the tail arrives there
            ctl.op      = OP_ROT_RIGHT;
            out_load    = step_sum >= (CntW+1)'(CAPACITY);
            out_value_d = cell_val[CAPACITY-1];
            out_last_d  = step_q == StepW'(CAPACITY - 1);
          end else begin
            ctl.op      = OP_ROT_LEFT;
            out_load    = (CntW+1)'(step_q) < (CntW+1)'(count_q);
            out_value_d = cell_val[0];
            out_last_d  = (CntW+1)'(step_q) + 1'b1 == (CntW+1)'(count_q);
          end
          if (step_q == StepW'(CAPACITY - 1)) begin
            state_d = FSM_IDLE;
          end
        end
      end
      default: state_d = FSM_IDLE;
    endcase

    out_count_d = COUNT_W'(count_d);
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FSM_IDLE;
      count_q     <= '0;
      step_q      <= '0;
      desc_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      step_q      <= step_d;
      desc_q      <= desc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_status_q <= out_status_d;
      out_value_q  <= out_value_d;
      out_count_q  <= out_count_d;
      out_last_q   <= out_last_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_count_q, out_value_q};
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tlast  = out_last_q;

endmodule

@@ rtl/slidu_checker.sv @@
// port-level checks for the sorted list unit, bound to the top level
`include "sorted_list_insert_delete_unit_assert.svh"

module slidu_checker import slidu_pkg::*; #(
  parameter int unsigned CAPACITY = 32
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [31:0] s_axis_tdata,
  input logic [1:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata,
  input logic [2:0]  m_axis_tuser,
  input logic        m_axis_tlast
);

  logic non_entry;
  assign non_entry = m_axis_tvalid && (m_axis_tuser != ST_ENTRY);

  // a stalled word keeps its contents
  `SLIDU_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "stalled output word changed")

  // a command is only taken when the result register can take its word
  `SLIDU_ASSERT_IMPLY(a_in_gated, s_axis_tready, !m_axis_tvalid || m_axis_tready, "input ready while result stalled")

  // status words are single-word answers with no entry value
  `SLIDU_ASSERT_IMPLY(a_status_last, non_entry, m_axis_tlast && (m_axis_tdata[31:0] == 32'd0), "status word not final or carries a value")

  // reported count never exceeds the list size
  `SLIDU_ASSERT_IMPLY(a_count_range, m_axis_tvalid, {1'b0, m_axis_tdata[37:32]} <= 7'(CAPACITY), "entry count beyond capacity")

endmodule

bind sorted_list_insert_delete_unit slidu_checker #(.CAPACITY(CAPACITY)) u_slidu_checker (.*);

@@ sim/sorted_list_checker.sv @@
// checker for the sorted list unit: shadow list, expected word queue and field compare
`timescale 1ns / 1ps

module sorted_list_checker import slidu_pkg::*; #(
  parameter int unsigned CAPACITY = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // value[31:0]
  input  logic [1:0]  s_axis_tuser,   // cmd[1:0]
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [39:0] m_axis_tdata,   // entry_value[31:0], entry_count[37:32], zero[39:38]
  input  logic [2:0]  m_axis_tuser,   // status[2:0]
  input  logic        m_axis_tlast,
  output int          fail_count_o,
  output int          pending_o
);

  typedef struct {
    status_e                   status;
    logic signed [VALUE_W-1:0] value;
    logic [COUNT_W-1:0]        count;
    logic                      last;
  } list_word_t;

  logic signed [VALUE_W-1:0] shadow_vals [CAPACITY];
  int unsigned               shadow_len;
  list_word_t                awaited_words [$];
  int                        mismatch_count;

  function automatic void queue_word(status_e status, logic signed [VALUE_W-1:0] value,
                                     logic last);
    list_word_t w;
    w.status = status;
    w.value  = value;
    w.count  = shadow_len[COUNT_W-1:0];
    w.last   = last;
    awaited_words.push_back(w);
  endfunction

  // applies one command to the shadow list and queues the words it should produce
  function automatic void run_list_command(cmd_e cmd, logic signed [VALUE_W-1:0] value);
    int unsigned pos;
    int unsigned idx;
    pos = 0;
    case (cmd)
      CMD_INSERT: begin
        if (shadow_len >= CAPACITY) begin
          queue_word(ST_FULL, '0, 1'b1);
        end else begin
          // equal entries stay ahead of the new one
          while (pos < shadow_len && !(shadow_vals[pos] > value)) pos++;
          for (idx = shadow_len; idx > pos; idx--) shadow_vals[idx] = shadow_vals[idx-1];
          shadow_vals[pos] = value;
          shadow_len++;
          queue_word(ST_DONE, '0, 1'b1);
        end
      end
      CMD_DELETE: begin
        while (pos < shadow_len && shadow_vals[pos] != value) pos++;
        if (pos >= shadow_len) begin
          queue_word(ST_MISSING, '0, 1'b1);
        end else begin
          for (idx = pos; idx + 1 < shadow_len; idx++) shadow_vals[idx] = shadow_vals[idx+1];
          shadow_len--;
          queue_word(ST_DONE, '0, 1'b1);
        end
      end
      default: begin
        if (shadow_len == 0) begin
          queue_word(ST_EMPTY, '0, 1'b1);
        end else begin
          for (pos = 0; pos < shadow_len; pos++) begin
            idx = (cmd == CMD_READ_ASC) ? pos : shadow_len - 1 - pos;
            queue_word(ST_ENTRY, shadow_vals[idx], pos + 1 == shadow_len);
          end
        end
      end
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    list_word_t exp_w;
    if (!rst_ni) begin
      shadow_len = 0;
      awaited_words.delete();
      mismatch_count = 0;
      pending_o <= 0;
    end else begin
      // output side first: a word leaving now belongs to an earlier command
      if (m_axis_tvalid && m_axis_tready) begin
        if (awaited_words.size() == 0) begin
          $error("unexpected word: status %0d value %0d", m_axis_tuser,
                 $signed(m_axis_tdata[31:0]));
          mismatch_count++;
        end else begin
          exp_w = awaited_words.pop_front();
          if (m_axis_tuser !== exp_w.status) begin
            $error("field status expected %0d actual %0d", exp_w.status, m_axis_tuser);
            mismatch_count++;
          end
          if (m_axis_tdata[31:0] !== exp_w.value) begin
            $error("field entry_value expected %0d actual %0d", exp_w.value,
                   $signed(m_axis_tdata[31:0]));
            mismatch_count++;
          end
          if (m_axis_tdata[37:32] !== exp_w.count) begin
            $error("field entry_count expected %0d actual %0d", exp_w.count,
                   m_axis_tdata[37:32]);
            mismatch_count++;
          end
          if (m_axis_tlast !== exp_w.last) begin
            $error("field last expected %0d actual %0d", exp_w.last, m_axis_tlast);
            mismatch_count++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        run_list_command(cmd_e'(s_axis_tuser), s_axis_tdata);
      end
      pending_o <= awaited_words.size();
    end
  end

  assign fail_count_o = mismatch_count;

endmodule

@@ sim/tb_top.sv @@
// testbench top for the sorted list unit: clock, reset, stimulus, watchdog and verdict
`timescale 1ns / 1ps

module tb_top;
  import slidu_pkg::*;

  localparam int unsigned CAPACITY     = 32;
  localparam int unsigned IDLE_LIMIT   = 4000;
  localparam int unsigned SETTLE_WAIT  = 3 * CAPACITY + 16;
  localparam int unsigned RANDOM_WORDS = 180;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;   // value[31:0]
  logic [1:0]  s_axis_tuser;   // cmd[1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;   // entry_value[31:0], entry_count[37:32], zero[39:38]
  logic [2:0]  m_axis_tuser;   // status[2:0]
  logic        m_axis_tlast;

  int          fail_count;
  int          pending_words;
  logic [31:0] recent_vals [$];
  int          burst_left;

  sorted_list_insert_delete_unit #(
    .CAPACITY(CAPACITY)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  sorted_list_checker #(
    .CAPACITY(CAPACITY)
  ) checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast),
    .fail_count_o (fail_count),
    .pending_o    (pending_words)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // mix of extremes, a narrow band that makes duplicates, and full-range values
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 5))
      0: return 32'($signed($urandom_range(0, 16)) - 8);
      1: begin
        case ($urandom_range(0, 3))
          0: return 32'h8000_0000;
          1: return 32'h7fff_ffff;
          2: return 32'h0000_0000;
          default: return 32'hffff_ffff;
        endcase
      end
      2: begin
        if (recent_vals.size() > 0) return recent_vals[$urandom_range(0, recent_vals.size() - 1)];
        return $urandom();
      end
      default: return $urandom();
    endcase
  endfunction

  function automatic cmd_e pick_cmd(int unsigned ins_pct, int unsigned del_pct);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < ins_pct) return CMD_INSERT;
    if (r < ins_pct + del_pct) return CMD_DELETE;
    return $urandom_range(0, 1) ? CMD_READ_ASC : CMD_READ_DESC;
  endfunction

  // one command word, then a random gap at the end of a burst
  task automatic send_word(input cmd_e cmd, input logic [31:0] value);
    int unsigned gap;
    if (cmd == CMD_INSERT) begin
      recent_vals.push_back(value);
      if (recent_vals.size() > 40) recent_vals.delete(0);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= value;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (burst_left == 0) begin
      gap = $urandom_range(0, 1) ? $urandom_range(1, 6) : 0;
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 20);
    end else begin
      burst_left--;
    end
  endtask

  task automatic hold_until_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_words != 0) @(posedge clk_i);
  endtask

  task automatic random_delete();
    if (recent_vals.size() > 0 && $urandom_range(0, 9) < 7) begin
      send_word(CMD_DELETE, recent_vals[$urandom_range(0, recent_vals.size() - 1)]);
    end else begin
      send_word(CMD_DELETE, pick_value());
    end
  endtask

  // receiver: the ready pattern keeps switching among always-ready, coin-flip and mostly-low modes
  initial begin
    int unsigned rx_mode;
    m_axis_tready = 1'b0;
    forever begin
      rx_mode = $urandom_range(0, 2);
      repeat ($urandom_range(20, 80)) begin
        @(posedge clk_i);
        case (rx_mode)
          0: m_axis_tready <= 1'b1;
          1: m_axis_tready <= 1'($urandom_range(0, 1));
          default: m_axis_tready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // watchdog on cycles with no word moving on either side
  initial begin
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("status: fail");
    $finish;
  end

  initial begin
    cmd_e        cmd;
    int unsigned ins_pct;
    int unsigned del_pct;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = CMD_INSERT;
    burst_left    = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty list: reads and a delete with nothing to find
    send_word(CMD_READ_ASC, 32'hffff_ffff);
    send_word(CMD_READ_DESC, 32'h0000_0000);
    send_word(CMD_DELETE, 32'd5);
    // extremes and duplicates
    send_word(CMD_INSERT, 32'h0000_0000);
    send_word(CMD_INSERT, 32'h7fff_ffff);
    send_word(CMD_INSERT, 32'h8000_0000);
    send_word(CMD_INSERT, 32'hffff_ffff);
    send_word(CMD_INSERT, 32'd5);
    send_word(CMD_INSERT, 32'd5);
    send_word(CMD_INSERT, 32'd1);
    send_word(CMD_READ_ASC, 32'h0000_0000);
    send_word(CMD_READ_DESC, 32'hffff_ffff);
    send_word(CMD_DELETE, 32'd5);
    send_word(CMD_DELETE, 32'd42);
    send_word(CMD_DELETE, 32'h8000_0000);
    send_word(CMD_DELETE, 32'h7fff_ffff);
    send_word(CMD_READ_ASC, 32'haaaa_aaaa);
    send_word(CMD_INSERT, 32'haaaa_aaaa);
    send_word(CMD_INSERT, 32'h5555_5555);
    send_word(CMD_READ_DESC, 32'h5555_5555);
    hold_until_drained();

    // fill, mix, drain, mix: the fill phase runs the list into the full case
    for (int unsigned n = 0; n < RANDOM_WORDS; n++) begin
      if (n == 60 || n == 120) hold_until_drained();
      if (n < 60) begin
        ins_pct = 90;
        del_pct = 4;
      end else if (n >= 120 && n < 170) begin
        ins_pct = 8;
        del_pct = 82;
      end else begin
        ins_pct = 45;
        del_pct = 40;
      end
      cmd = pick_cmd(ins_pct, del_pct);
      if (cmd == CMD_DELETE) begin
        random_delete();
      end else begin
        send_word(cmd, pick_value());
      end
    end

    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_words != 0) @(posedge clk_i);
    repeat (SETTLE_WAIT) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

@@ sorted_list_insert_delete_unit.f @@
+incdir+rtl
rtl/slidu_pkg.sv
rtl/slidu_cell.sv
rtl/sorted_list_insert_delete_unit.sv
rtl/slidu_checker.sv
sim/sorted_list_checker.sv
sim/tb_top.sv
